[rtl/assert_macros.svh]
// Assertion helpers for the RTL files (included by xcr_queue).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge, off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/xcr_pkg.sv]
package xcr_pkg;

  // Frame layout: SOH, block number, complement, payload, checksum
  localparam int PAYLOAD_BYTES = 128;
  localparam logic [7:0] FRAME_END = 8'(3 + PAYLOAD_BYTES);

  // Depth of the result-group queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Control characters
  localparam logic [7:0] CH_SOH       = 8'd1;
  localparam logic [7:0] CH_EOT       = 8'd4;
  localparam logic [7:0] CH_ACK       = 8'd6;
  localparam logic [7:0] CH_NAK       = 8'd21;
  localparam logic [7:0] CH_CANCEL_UP = 8'd66;
  localparam logic [7:0] CH_CANCEL_LO = 8'd98;

  // Input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] K_TX      = 2'd0;
  localparam logic [1:0] K_PAYLOAD = 2'd1;
  localparam logic [1:0] K_COMMIT  = 2'd2;
  localparam logic [1:0] K_DISCARD = 2'd3;

  // Session status
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CANCEL  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_RETRIES  = 2'd1;
  localparam logic [1:0] CFG_REQ_CHAR = 2'd2;

  // Configuration reset values
  localparam logic [15:0] INTERVAL_RST = 16'd500;
  localparam logic [7:0]  RETRIES_RST  = 8'd100;
  localparam logic [7:0]  REQ_CHAR_RST = 8'd21;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } xcr_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } xcr_out_t;

  // Up to two results caused by one input item
  typedef struct packed {
    logic       two_res;
    logic [1:0] kind0;
    logic [7:0] value0;
    logic [1:0] kind1;
    logic [7:0] value1;
    logic [1:0] status;
  } xcr_grp_t;

endpackage

[rtl/xmodem_checksum_receiver.sv]
// XMODEM checksum receiver: one input item (byte or tick) accepted per cycle while in_stall is low.
// Each item's result group is written into the queue when accepted, then registered in xcr_back.
// One result per cycle while out_stall is low; an item with two results gives them in turn,
// and input stalls only when QUEUE_DEPTH result groups wait in the queue.
// Reset (rst, synchronous): session in request phase, registers at 500/100/21,
// queue and output emptied; no clearing pass.
module xmodem_checksum_receiver #(
  parameter int QUEUE_DEPTH = xcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  xcr_pkg::xcr_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output xcr_pkg::xcr_out_t out_item
);
  import xcr_pkg::*;

  logic     grp_push;
  xcr_grp_t grp;
  logic     grp_full;
  logic     head_valid;
  xcr_grp_t head_data;
  logic     pop;

  // Front: protocol decode and session state
  xcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .grp_push  (grp_push),
    .grp       (grp),
    .grp_full  (grp_full)
  );

  // Result-group queue
  xcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (grp_push),
    .push_data  (grp),
    .full       (grp_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Back: serializes groups into result items
  xcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

[rtl/xcr_front.sv]
module xcr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  xcr_pkg::xcr_in_t in_item,
  output logic             grp_push,
  output xcr_pkg::xcr_grp_t grp,
  input  logic             grp_full
);
  import xcr_pkg::*;

  localparam logic [1:0] PH_REQUEST = 2'd0;
  localparam logic [1:0] PH_FRAME   = 2'd1;
  localparam logic [1:0] PH_BETWEEN = 2'd2;

  logic [15:0] request_interval;
  logic [7:0]  request_retries;
  logic [7:0]  request_char;

  logic [1:0]  phase, phase_next;
  logic [7:0]  frame_pos, frame_pos_next;
  logic [7:0]  expected_block, expected_block_next;
  logic [7:0]  got_block, got_block_next;
  logic        block_ok, block_ok_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  requests_sent, requests_sent_next;

  logic        accept;
  logic        grp_valid;
  logic        do_restart;
  logic [15:0] tick_inc;
  logic [7:0]  req_inc;
  logic [7:0]  b;

  assign in_stall = grp_full;
  assign accept   = in_valid && !grp_full;
  assign grp_push = accept && grp_valid;
  assign b        = in_item.rx_byte;

  // Saturating tick count and incremented request count
  assign tick_inc = tick_count + {15'd0, (tick_count != 16'hFFFF)};
  assign req_inc  = requests_sent + 8'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      request_interval <= INTERVAL_RST;
      request_retries  <= RETRIES_RST;
      request_char     <= REQ_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL: request_interval <= cfg_data;
        CFG_RETRIES:  request_retries  <= cfg_data[7:0];
        CFG_REQ_CHAR: request_char     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Protocol decode: next state and the result group of this item
  always_comb begin
    phase_next          = phase;
    frame_pos_next      = frame_pos;
    expected_block_next = expected_block;
    got_block_next      = got_block;
    block_ok_next       = block_ok;
    running_sum_next    = running_sum;
    tick_count_next     = tick_count;
    requests_sent_next  = requests_sent;
    grp_valid           = 1'b0;
    grp                 = '0;
    do_restart          = 1'b0;

    case (phase)
      PH_REQUEST: begin
        if (in_item.op == OP_TICK) begin
          if (tick_inc < request_interval) begin
            tick_count_next = tick_inc;
          end else begin
            tick_count_next = '0;
            grp_valid       = 1'b1;
            grp.kind0       = K_TX;
            grp.value0      = request_char;
            if (req_inc >= request_retries) begin
              grp.status = ST_TIMEOUT;
              do_restart = 1'b1;
            end else begin
              grp.status         = ST_BUSY;
              requests_sent_next = req_inc;
            end
          end
        end else begin
          tick_count_next = '0;
          if (b == CH_CANCEL_UP || b == CH_CANCEL_LO) begin
            grp_valid  = 1'b1;
            grp.kind0  = K_DISCARD;
            grp.status = ST_CANCEL;
            do_restart = 1'b1;
          end else if (b == CH_SOH) begin
            phase_next       = PH_FRAME;
            frame_pos_next   = 8'd1;
            running_sum_next = '0;
            block_ok_next    = 1'b0;
            got_block_next   = '0;
          end else if (b == CH_EOT) begin
            grp_valid   = 1'b1;
            grp.two_res = 1'b1;
            grp.kind0   = K_TX;
            grp.value0  = CH_EOT;
            grp.kind1   = K_TX;
            grp.value1  = CH_ACK;
            grp.status  = ST_DONE;
            do_restart  = 1'b1;
          end
        end
      end
      PH_FRAME: begin
        if (in_item.op == OP_BYTE) begin
          if (frame_pos == 8'd1) begin
            got_block_next = b;
            frame_pos_next = 8'd2;
          end else if (frame_pos == 8'd2) begin
            block_ok_next  = (~b == got_block) && (got_block == expected_block);
            frame_pos_next = 8'd3;
          end else if (frame_pos < FRAME_END) begin
            running_sum_next = running_sum + b;
            frame_pos_next   = frame_pos + 8'd1;
            grp_valid        = 1'b1;
            grp.kind0        = K_PAYLOAD;
            grp.value0       = b;
            grp.status       = ST_BUSY;
          end else begin
            // Checksum byte: commit with ACK or discard with NAK
            grp_valid   = 1'b1;
            grp.two_res = 1'b1;
            grp.kind1   = K_TX;
            grp.status  = ST_BUSY;
            if (block_ok && running_sum == b) begin
              expected_block_next = expected_block + 8'd1;
              grp.kind0           = K_COMMIT;
              grp.value1          = CH_ACK;
            end else begin
              grp.kind0  = K_DISCARD;
              grp.value1 = CH_NAK;
            end
            phase_next       = PH_BETWEEN;
            frame_pos_next   = '0;
            running_sum_next = '0;
            block_ok_next    = 1'b0;
          end
        end
      end
      PH_BETWEEN: begin
        if (in_item.op == OP_BYTE) begin
          if (b == CH_SOH) begin
            phase_next       = PH_FRAME;
            frame_pos_next   = 8'd1;
            running_sum_next = '0;
            block_ok_next    = 1'b0;
            got_block_next   = '0;
          end else if (b == CH_EOT) begin
            grp_valid   = 1'b1;
            grp.two_res = 1'b1;
            grp.kind0   = K_TX;
            grp.value0  = CH_EOT;
            grp.kind1   = K_TX;
            grp.value1  = CH_ACK;
            grp.status  = ST_DONE;
            do_restart  = 1'b1;
          end
        end
      end
      default: begin
        do_restart = 1'b1;
      end
    endcase

    // Session restart returns all protocol state to reset values
    if (do_restart) begin
      phase_next          = PH_REQUEST;
      frame_pos_next      = '0;
      expected_block_next = 8'd1;
      got_block_next      = '0;
      block_ok_next       = 1'b0;
      running_sum_next    = '0;
      tick_count_next     = '0;
      requests_sent_next  = '0;
    end
  end

  // Protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_REQUEST;
      frame_pos      <= '0;
      expected_block <= 8'd1;
      got_block      <= '0;
      block_ok       <= 1'b0;
      running_sum    <= '0;
      tick_count     <= '0;
      requests_sent  <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      frame_pos      <= frame_pos_next;
      expected_block <= expected_block_next;
      got_block      <= got_block_next;
      block_ok       <= block_ok_next;
      running_sum    <= running_sum_next;
      tick_count     <= tick_count_next;
      requests_sent  <= requests_sent_next;
    end
  end

endmodule

[rtl/xcr_queue.sv]
`include "assert_macros.svh"

module xcr_queue #(
  parameter int DEPTH = xcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xcr_pkg::xcr_grp_t push_data,
  output logic              full,
  output logic              head_valid,
  output xcr_pkg::xcr_grp_t head_data,
  input  logic              pop
);
  import xcr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xcr_grp_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  `ASSERT_RST(a_count_bound, clk, rst, count <= CW'(DEPTH), "queue count above depth")
  `ASSERT_RST(a_pop_nonempty, clk, rst, pop |-> count != '0, "pop from empty queue")
  `ASSERT_RST(a_count_hold, clk, rst, (!push && !pop) |=> count == $past(count), "count moved while idle")

endmodule

[rtl/xcr_back.sv]
module xcr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  xcr_pkg::xcr_grp_t head_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output xcr_pkg::xcr_out_t out_item
);
  import xcr_pkg::*;

  logic     sel;
  logic     load;
  logic     is_last;
  xcr_out_t res;

  assign load    = !out_valid || !out_stall;
  assign is_last = sel || !head_data.two_res;
  assign pop     = load && head_valid && is_last;

  // Pick the current result of the head group
  always_comb begin
    res        = '0;
    res.kind   = sel ? head_data.kind1 : head_data.kind0;
    res.value  = sel ? head_data.value1 : head_data.value0;
    res.status = head_data.status;
    res.last   = is_last;
  end

  // Result select within the group
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (load && head_valid) begin
      sel <= !is_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_item <= res;
    end
  end

endmodule
